// ===== rtl/core/hsw_pkg.sv =====
// Shared types, constants and fixed-point helpers for the int8 hard-swish pipeline.
// No dependencies; used by every module under rtl/core except hsw_checker.
package hsw_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IN_ZP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ZP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MUL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_EXP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELU_MUL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELU_EXP = 3'd5;

  localparam logic signed [15:0] MAX16 = 16'sh7fff;
  localparam logic signed [15:0] MIN16 = 16'sh8000;
  localparam logic signed [15:0] MUL_RESET = 16'sd16384;
  localparam logic signed [16:0] ACT_MAX = 17'sd127;
  localparam logic signed [16:0] ACT_MIN = -17'sd128;
  localparam logic signed [32:0] NUDGE_POS = 33'sd16384;
  localparam logic signed [32:0] NUDGE_NEG = -33'sd16383;
  localparam logic signed [32:0] TRUNC_BIAS = 33'sd32767;

  typedef struct packed {
    logic signed [7:0]  in_zp;
    logic signed [7:0]  out_zp;
    logic signed [15:0] out_mul;
    logic signed [4:0]  out_exp;
    logic signed [15:0] relu_mul;
    logic signed [4:0]  relu_exp;
  } cfg_t;

  // raw products after the input scaling stages
  typedef struct packed {
    logic signed [31:0] ab_out;
    logic signed [31:0] ab_relu;
    logic               sat_out;
    logic               sat_relu;
    logic               last;
  } prod2_t;

  // raw product of the two branches
  typedef struct packed {
    logic signed [31:0] ab;
    logic               last;
  } prod1_t;

  // finish of the doubling high multiply: nudge, then divide by 2^15 toward zero
  function automatic logic signed [15:0] srdhm_fin(input logic signed [31:0] ab,
                                                   input logic sat);
    logic signed [32:0] s;
    logic signed [32:0] t;
    s = 33'(ab) + (ab[31] ? NUDGE_NEG : NUDGE_POS);
    t = s[32] ? s + TRUNC_BIAS : s;
    return sat ? MAX16 : t[30:15];
  endfunction

  // right shift by n (0..16), ties away from zero
  function automatic logic signed [15:0] rshift_round(input logic signed [15:0] x,
                                                      input logic [4:0] n);
    logic signed [16:0] xe;
    logic signed [16:0] q;
    logic [16:0] mask;
    logic [16:0] rem;
    logic [16:0] thr;
    logic [16:0] sum;
    xe   = 17'(x);
    mask = (17'd1 << n) - 17'd1;
    rem  = xe & mask;
    thr  = (mask >> 1) + 17'(x[15]);
    q    = xe >>> n;
    sum  = q + {16'b0, (rem > thr)};
    return sum[15:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [30:0] v);
    logic signed [15:0] r;
    if (v > 31'sd32767) begin
      r = MAX16;
    end else if (v < -31'sd32768) begin
      r = MIN16;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // saturating left shift by n (0..14)
  function automatic logic signed [15:0] sat_lshift(input logic signed [15:0] v,
                                                    input logic [3:0] n);
    logic signed [30:0] w;
    w = 31'(v) <<< n;
    return sat16(w);
  endfunction

endpackage

// ===== rtl/core/int8_hard_swish_activation.sv =====
// Top level of the int8 hard-swish activation: configuration registers and the five-stage pipeline.
// Depends on hsw_pkg, hsw_scale, hsw_relu and hsw_requant.
// Accepts one item per clock while the output is not stalled; a stall holds each occupied stage
// in place unless an empty stage lies after it. The five register stages are: scaling, the two
// 16x16 products, rounding with the relu6 shift, the branch product, and requantization into the
// output register. Configuration writes take effect on the next cycle and must be made while the
// pipeline is empty.
module int8_hard_swish_activation (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hsw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [7:0]                in_sample,
  input  logic                             in_last_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [7:0]                out_activation,
  output logic                             out_last_out
);
  import hsw_pkg::*;

  cfg_t   cfg_r;
  logic   sc_valid;
  logic   sc_ready;
  prod2_t sc_data;
  logic   rl_valid;
  logic   rl_ready;
  prod1_t rl_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_zp    <= '0;
      cfg_r.out_zp   <= '0;
      cfg_r.out_mul  <= MUL_RESET;
      cfg_r.out_exp  <= '0;
      cfg_r.relu_mul <= MUL_RESET;
      cfg_r.relu_exp <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_ZP:    cfg_r.in_zp    <= cfg_wdata[7:0];
        REG_OUT_ZP:   cfg_r.out_zp   <= cfg_wdata[7:0];
        REG_OUT_MUL:  cfg_r.out_mul  <= cfg_wdata;
        REG_OUT_EXP:  cfg_r.out_exp  <= cfg_wdata[4:0];
        REG_RELU_MUL: cfg_r.relu_mul <= cfg_wdata;
        REG_RELU_EXP: cfg_r.relu_exp <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  hsw_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .sample   (in_sample),
    .last_in  (in_last_in),
    .dn_valid (sc_valid),
    .dn_ready (sc_ready),
    .dn_data  (sc_data)
  );

  hsw_relu u_relu (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (sc_valid),
    .up_ready (sc_ready),
    .up_data  (sc_data),
    .dn_valid (rl_valid),
    .dn_ready (rl_ready),
    .dn_data  (rl_data)
  );

  hsw_requant u_requant (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .up_valid   (rl_valid),
    .up_ready   (rl_ready),
    .up_data    (rl_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .activation (out_activation),
    .last_out   (out_last_out)
  );

endmodule

// ===== rtl/core/hsw_scale.sv =====
// Stages 1-2: zero point removal, x128 scaling, relu6 pre-shift, both 16x16 products.
// Depends on hsw_pkg.
module hsw_scale (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hsw_pkg::cfg_t         cfg,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic signed [7:0]     sample,
  input  logic                  last_in,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output hsw_pkg::prod2_t       dn_data
);
  import hsw_pkg::*;

  logic               s1_v_r;
  logic signed [15:0] s1_scaled_r;
  logic signed [15:0] s1_rpre_r;
  logic               s1_last_r;
  logic               s2_v_r;
  prod2_t             s2_r;

  logic               s1_en;
  logic               s2_en;
  logic signed [8:0]  x;
  logic signed [15:0] scaled_nxt;
  logic signed [15:0] rpre_nxt;
  prod2_t             s2_nxt;

  assign s2_en    = !s2_v_r || dn_ready;
  assign s1_en    = !s1_v_r || s2_en;
  assign up_ready = s1_en;
  assign dn_valid = s2_v_r;
  assign dn_data  = s2_r;

  always_comb begin
    x          = 9'(sample) - 9'(cfg.in_zp);
    scaled_nxt = {x, 7'b0};
    if (cfg.relu_exp > 5'sd0) begin
      rpre_nxt = sat_lshift(scaled_nxt, cfg.relu_exp[3:0] - 4'd1);
    end else begin
      rpre_nxt = scaled_nxt;
    end
  end

  always_comb begin
    s2_nxt.ab_out   = s1_scaled_r * cfg.out_mul;
    s2_nxt.ab_relu  = s1_rpre_r * cfg.relu_mul;
    s2_nxt.sat_out  = (s1_scaled_r == MIN16) && (cfg.out_mul == MIN16);
    s2_nxt.sat_relu = (s1_rpre_r == MIN16) && (cfg.relu_mul == MIN16);
    s2_nxt.last     = s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_en) s1_v_r <= up_valid;
      if (s2_en) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && up_valid) begin
      s1_scaled_r <= scaled_nxt;
      s1_rpre_r   <= rpre_nxt;
      s1_last_r   <= last_in;
    end
    if (s2_en && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

// ===== rtl/core/hsw_relu.sv =====
// Stages 3-4: rounding of both products, relu6 post-shift and mapping, branch product.
// Depends on hsw_pkg.
module hsw_relu (
  input  logic            clk,
  input  logic            rst_n,
  input  hsw_pkg::cfg_t   cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  hsw_pkg::prod2_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output hsw_pkg::prod1_t dn_data
);
  import hsw_pkg::*;

  logic               s3_v_r;
  logic signed [15:0] s3_pre_out_r;
  logic [14:0]        s3_r15_r;
  logic               s3_last_r;
  logic               s4_v_r;
  prod1_t             s4_r;

  logic               s3_en;
  logic               s4_en;
  logic signed [15:0] pre_out_nxt;
  logic signed [15:0] rm;
  logic signed [15:0] rp;
  logic [14:0]        r15_nxt;
  prod1_t             s4_nxt;

  assign s4_en    = !s4_v_r || dn_ready;
  assign s3_en    = !s3_v_r || s4_en;
  assign up_ready = s3_en;
  assign dn_valid = s4_v_r;
  assign dn_data  = s4_r;

  always_comb begin
    pre_out_nxt = srdhm_fin(up_data.ab_out, up_data.sat_out);
    rm          = srdhm_fin(up_data.ab_relu, up_data.sat_relu);
    if (cfg.relu_exp > 5'sd0) begin
      rp = sat_lshift(rm, 4'd1);
    end else if (cfg.relu_exp[4]) begin
      rp = rshift_round(rm, 5'(-cfg.relu_exp));
    end else begin
      rp = rm;
    end
    // (v + 32768) >> 1
    r15_nxt = {~rp[15], rp[14:1]};
  end

  always_comb begin
    s4_nxt.ab   = $signed({1'b0, s3_r15_r}) * s3_pre_out_r;
    s4_nxt.last = s3_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s3_en) s3_v_r <= up_valid;
      if (s4_en) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && up_valid) begin
      s3_pre_out_r <= pre_out_nxt;
      s3_r15_r     <= r15_nxt;
      s3_last_r    <= up_data.last;
    end
    if (s4_en && s3_v_r) begin
      s4_r <= s4_nxt;
    end
  end

endmodule

// ===== rtl/core/hsw_requant.sv =====
// Stage 5: final rounding, output exponent shift, zero point and int8 clamp; output register.
// Depends on hsw_pkg.
module hsw_requant (
  input  logic              clk,
  input  logic              rst_n,
  input  hsw_pkg::cfg_t     cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  hsw_pkg::prod1_t   up_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] activation,
  output logic              last_out
);
  import hsw_pkg::*;

  logic              s5_v_r;
  logic signed [7:0] s5_act_r;
  logic              s5_last_r;

  logic               s5_en;
  logic signed [15:0] prod;
  logic [4:0]         fshift;
  logic signed [15:0] shifted;
  logic signed [16:0] sum;
  logic signed [7:0]  act_nxt;

  assign s5_en      = !s5_v_r || out_ready;
  assign up_ready   = s5_en;
  assign out_valid  = s5_v_r;
  assign activation = s5_act_r;
  assign last_out   = s5_last_r;

  always_comb begin
    prod    = srdhm_fin(up_data.ab, 1'b0);
    fshift  = cfg.out_exp[4] ? 5'(-cfg.out_exp) : 5'd0;
    shifted = rshift_round(prod, fshift);
    sum     = 17'(shifted) + 17'(cfg.out_zp);
    if (sum > ACT_MAX) begin
      act_nxt = ACT_MAX[7:0];
    end else if (sum < ACT_MIN) begin
      act_nxt = ACT_MIN[7:0];
    end else begin
      act_nxt = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (s5_en) begin
      s5_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_en && up_valid) begin
      s5_act_r  <= act_nxt;
      s5_last_r <= up_data.last;
    end
  end

endmodule

// ===== rtl/core/hsw_checker.sv =====
// Port-level checks for int8_hard_swish_activation, attached by bind.
// Depends only on the top level's ports.
module hsw_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] out_activation,
  input logic              out_last_out
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_activation) && $stable(out_last_out))
    else $error("stalled item changed or dropped");

  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side can move");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && in_ready, 5) &&
    $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) &&
    $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3) && $past(out_ready, 4)
    |-> out_valid)
    else $error("item did not arrive after five cycles");

endmodule

bind int8_hard_swish_activation hsw_checker u_hsw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_activation (out_activation),
  .out_last_out   (out_last_out)
);
